/* design/adam_param_update_unit_defines.svh */
// Assertion macros for the Adam parameter update unit.
`ifndef ADAM_PARAM_UPDATE_UNIT_DEFINES_SVH
`define ADAM_PARAM_UPDATE_UNIT_DEFINES_SVH

// cond implies prop in the same cycle; sampled on clk, off while rst_n is low
`define APU_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("apu: implication check failed");

// bad never holds; sampled on clk, off while rst_n is low
`define APU_NEVER(lbl, bad) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error("apu: forbidden condition seen");

`endif

/* design/apu_pkg.sv */
// Shared types and constants for the Adam parameter update unit.
package apu_pkg;

    localparam int DW  = 32;
    localparam int FB  = 24;
    localparam int VW  = DW - 1;
    localparam int CW  = FB + 1;
    localparam int IW  = 3;
    localparam int QCW = 41;

    localparam logic [CW-1:0] ONE = {1'b1, {FB{1'b0}}};

    localparam logic [CW-1:0] STEP_SIZE_RST          = CW'(16777);
    localparam logic [CW-1:0] MEAN_DECAY_RST         = CW'(15099494);
    localparam logic [CW-1:0] SQUARE_DECAY_RST       = CW'(16760439);
    localparam logic [CW-1:0] MEAN_DECAY_POWER_RST   = CW'(15099494);
    localparam logic [CW-1:0] SQUARE_DECAY_POWER_RST = CW'(16760439);
    localparam logic [CW-1:0] EPSILON_RST            = CW'(168);

    typedef enum logic [IW-1:0] {
        REG_STEP_SIZE          = IW'(0),
        REG_MEAN_DECAY         = IW'(1),
        REG_SQUARE_DECAY       = IW'(2),
        REG_MEAN_DECAY_POWER   = IW'(3),
        REG_SQUARE_DECAY_POWER = IW'(4),
        REG_EPSILON            = IW'(5)
    } apu_reg_t;

    typedef struct packed {
        logic signed [DW-1:0] param_value;
        logic signed [DW-1:0] grad_value;
        logic signed [DW-1:0] mean_value;
        logic [VW-1:0]        square_value;
        logic                 is_last;
    } apu_in_t;

    typedef struct packed {
        logic signed [DW-1:0] new_param;
        logic signed [DW-1:0] new_mean;
        logic [VW-1:0]        new_square;
        logic                 div_error;
        logic                 last_out;
    } apu_out_t;

    // clipped coefficients and derived complements
    typedef struct packed {
        logic [CW-1:0] lr;
        logic [CW-1:0] b1;
        logic [CW-1:0] nb1;
        logic [CW-1:0] b2;
        logic [CW-1:0] nb2;
        logic [CW-1:0] c1;
        logic [CW-1:0] c2;
        logic [CW-1:0] eps;
    } apu_coef_t;

    // word handed from front to back through the queue
    typedef struct packed {
        logic signed [DW-1:0] p;
        logic signed [DW-1:0] mn;
        logic [VW-1:0]        vn;
        logic                 err;
        logic                 last;
    } apu_mid_t;

    typedef struct packed {
        logic tail_vld;
        logic stall;
    } apu_fst_t;

    typedef struct packed {
        logic full;
        logic empty;
    } apu_qst_t;

endpackage

/* design/apu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module apu_div #(
    parameter int NW  = 56,
    parameter int DNW = 25,
    parameter int QW  = 32,
    parameter int SW  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [NW-1:0]  num,
    input  logic [DNW-1:0] den,
    input  logic [SW-1:0]  side_in,
    output logic           out_vld,
    output logic [QW-1:0]  quo,
    output logic [SW-1:0]  side_out
);

    localparam int EW   = (NW > QW) ? NW : QW + 1;
    localparam int HW   = EW - QW;
    localparam int CMPW = (HW > DNW) ? HW : DNW;

    logic [DNW-1:0] rem_reg  [QW+1];
    logic [QW-1:0]  acc_reg  [QW+1];
    logic [DNW-1:0] den_reg  [QW+1];
    logic           ovf_reg  [QW+1];
    logic [SW-1:0]  side_reg [QW+1];
    logic           vld_reg  [QW+1];

    logic [EW-1:0] num_ext;
    logic [HW-1:0] num_hi;
    logic          ovf_next;

    always_comb
    begin
        num_ext  = EW'(num);
        num_hi   = num_ext[EW-1:QW];
        ovf_next = CMPW'(num_hi) >= CMPW'(den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DNW'(num_hi);
            acc_reg[0]  <= num_ext[QW-1:0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [DNW:0]   trial;
        logic [DNW:0]   diff;
        logic           ge;
        logic [DNW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], acc_reg[k-1][QW-1]};
            diff     = trial - {1'b0, den_reg[k-1]};
            ge       = trial >= {1'b0, den_reg[k-1]};
            rem_next = ge ? diff[DNW-1:0] : trial[DNW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                acc_reg[k]  <= {acc_reg[k-1][QW-2:0], ge};
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign quo      = ovf_reg[QW] ? {QW{1'b1}} : acc_reg[QW];
    assign side_out = side_reg[QW];

endmodule

/* design/apu_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module apu_sqrt #(
    parameter int XW = 55,
    parameter int SW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [XW-1:0]       x,
    input  logic [SW-1:0]       side_in,
    output logic                out_vld,
    output logic [(XW+1)/2-1:0] root,
    output logic [SW-1:0]       side_out
);

    localparam int RW  = (XW + 1) / 2;
    localparam int PXW = 2 * RW;
    localparam int RMW = RW + 2;
    localparam int TW  = RW + 4;

    logic [PXW-1:0] xs_reg   [RW+1];
    logic [RMW-1:0] rem_reg  [RW+1];
    logic [RW-1:0]  root_reg [RW+1];
    logic [SW-1:0]  side_reg [RW+1];
    logic           vld_reg  [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_reg[0]   <= PXW'(x);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= RW; k++)
    begin : g_stage
        logic [TW-1:0] remsh;
        logic [TW-1:0] trial;
        logic [TW-1:0] diff;
        logic          ge;

        always_comb
        begin
            remsh = TW'({rem_reg[k-1], xs_reg[k-1][PXW-1 -: 2]});
            trial = TW'({root_reg[k-1], 2'b01});
            diff  = remsh - trial;
            ge    = remsh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xs_reg[k]   <= xs_reg[k-1] << 2;
                rem_reg[k]  <= ge ? diff[RMW-1:0] : remsh[RMW-1:0];
                root_reg[k] <= {root_reg[k-1][RW-2:0], ge};
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[RW];
    assign root     = root_reg[RW];
    assign side_out = side_reg[RW];

endmodule

/* design/apu_front.sv */
// Front end: accepts elements and computes the updated first and second moments.
module apu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  apu_pkg::apu_in_t    item,
    input  apu_pkg::apu_coef_t  coef,
    input  logic                out_ready,
    output logic                out_vld,
    output apu_pkg::apu_mid_t   out_word,
    output apu_pkg::apu_fst_t   st
);

    localparam int DW   = apu_pkg::DW;
    localparam int VW   = apu_pkg::VW;
    localparam int CW   = apu_pkg::CW;
    localparam int FB   = apu_pkg::FB;
    localparam int PW   = CW + DW + 1;
    localparam int SUMW = PW + 1;
    localparam int GGW  = 2 * DW;
    localparam int GRW  = GGW + 1;
    localparam int VPW  = CW + VW;
    localparam int VSW  = VPW + 1;

    localparam logic signed [SUMW-1:0] HALF_S = SUMW'({1'b1, {(FB-1){1'b0}}});
    localparam logic signed [SUMW-1:0] SMAX_X = SUMW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [SUMW-1:0] SMIN_X = -SMAX_X - 1;
    localparam logic [GRW-1:0]         HALF_G = GRW'({1'b1, {(FB-1){1'b0}}});
    localparam logic [GRW-1:0]         VMAX_G = GRW'({VW{1'b1}});
    localparam logic [VSW-1:0]         HALF_V = VSW'({1'b1, {(FB-1){1'b0}}});
    localparam logic [VSW-1:0]         VMAX_V = VSW'({VW{1'b1}});

    logic adv;

    // stage 1: products
    logic                 s1_vld_reg;
    logic signed [PW-1:0] s1_bm_reg, s1_gm_reg;
    logic [GGW-1:0]       s1_gg_reg;
    logic signed [DW-1:0] s1_p_reg;
    logic [VW-1:0]        s1_v_reg;
    logic                 s1_last_reg;
    logic [DW-1:0]        ag;

    // stage 2: rounded mean, squared gradient
    logic                 s2_vld_reg;
    logic signed [DW-1:0] s2_mn_reg, s2_p_reg;
    logic [VW-1:0]        s2_gsq_reg, s2_v_reg;
    logic                 s2_last_reg;
    logic signed [SUMW-1:0] msum, msh;
    logic signed [DW-1:0]   mn_next;
    logic [GRW-1:0]         gr, gsh;
    logic [VW-1:0]          gsq_next;

    // stage 3: second moment products
    logic                 s3_vld_reg;
    logic [VPW-1:0]       s3_vb_reg, s3_vg_reg;
    logic signed [DW-1:0] s3_mn_reg, s3_p_reg;
    logic                 s3_last_reg;

    // stage 4: output word
    logic                 s4_vld_reg;
    apu_pkg::apu_mid_t    s4_word_reg;
    logic [VSW-1:0]       vsum, vsh;
    apu_pkg::apu_mid_t    s4_word_next;

    assign adv = !s4_vld_reg || out_ready;

    always_comb
    begin
        ag = item.grad_value[DW-1] ? (~item.grad_value + 1'b1) : item.grad_value;

        msum = SUMW'(s1_bm_reg) + SUMW'(s1_gm_reg) + HALF_S;
        msh  = msum >>> FB;
        if (msh > SMAX_X)
        begin
            mn_next = DW'(SMAX_X);
        end
        else if (msh < SMIN_X)
        begin
            mn_next = DW'(SMIN_X);
        end
        else
        begin
            mn_next = DW'(msh);
        end

        gr       = GRW'(s1_gg_reg) + HALF_G;
        gsh      = gr >> FB;
        gsq_next = (gsh > VMAX_G) ? {VW{1'b1}} : gsh[VW-1:0];

        vsum = VSW'(s3_vb_reg) + VSW'(s3_vg_reg) + HALF_V;
        vsh  = vsum >> FB;
        s4_word_next.p    = s3_p_reg;
        s4_word_next.mn   = s3_mn_reg;
        s4_word_next.vn   = (vsh > VMAX_V) ? {VW{1'b1}} : vsh[VW-1:0];
        s4_word_next.err  = (coef.c1 == '0) || (coef.c2 == '0);
        s4_word_next.last = s3_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bm_reg   <= $signed({1'b0, coef.b1}) * item.mean_value;
            s1_gm_reg   <= $signed({1'b0, coef.nb1}) * item.grad_value;
            s1_gg_reg   <= ag * ag;
            s1_p_reg    <= item.param_value;
            s1_v_reg    <= item.square_value;
            s1_last_reg <= item.is_last;

            s2_mn_reg   <= mn_next;
            s2_gsq_reg  <= gsq_next;
            s2_p_reg    <= s1_p_reg;
            s2_v_reg    <= s1_v_reg;
            s2_last_reg <= s1_last_reg;

            s3_vb_reg   <= coef.b2 * s2_v_reg;
            s3_vg_reg   <= coef.nb2 * s2_gsq_reg;
            s3_mn_reg   <= s2_mn_reg;
            s3_p_reg    <= s2_p_reg;
            s3_last_reg <= s2_last_reg;

            s4_word_reg <= s4_word_next;
        end
    end

    assign out_vld     = s4_vld_reg;
    assign out_word    = s4_word_reg;
    assign st.tail_vld = s4_vld_reg;
    assign st.stall    = !adv;

endmodule

/* design/apu_fifo.sv */
// Short word queue between the front and back ends.
module apu_fifo #(
    parameter int DEPTH = 4,
    parameter int WW    = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_vld,
    output logic              push_ready,
    input  logic [WW-1:0]     push_word,
    output logic              pop_vld,
    input  logic              pop_ready,
    output logic [WW-1:0]     pop_word,
    output apu_pkg::apu_qst_t st
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WW-1:0]   mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            push, pop;

    always_comb
    begin
        push_ready  = count_reg != CNTW'(DEPTH);
        pop_vld     = count_reg != '0;
        push        = push_vld && push_ready;
        pop         = pop_vld && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign pop_word = mem[rd_ptr_reg];
    assign st.full  = !push_ready;
    assign st.empty = !pop_vld;

endmodule

/* design/apu_back.sv */
// Back end: bias correction, root, step division and parameter saturation.
module apu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  apu_pkg::apu_coef_t coef,
    input  logic               in_vld,
    output logic               in_ready,
    input  apu_pkg::apu_mid_t  in_word,
    output logic               result_valid,
    input  logic               result_stall,
    output apu_pkg::apu_out_t  result
);

    localparam int DW  = apu_pkg::DW;
    localparam int VW  = apu_pkg::VW;
    localparam int CW  = apu_pkg::CW;
    localparam int FB  = apu_pkg::FB;
    localparam int QCW = apu_pkg::QCW;
    localparam int N1W = DW + FB;
    localparam int N2W = VW + FB;
    localparam int XW  = VW + FB;
    localparam int RW  = (XW + 1) / 2;
    localparam int DDW = ((RW > CW) ? RW : CW) + 1;
    localparam int NQW = CW + DW + 1;
    localparam int FW  = ((QCW > DW) ? QCW : DW) + 2;

    localparam logic [QCW-1:0]       QCLAMP = {1'b1, {(QCW-1){1'b0}}};
    localparam logic signed [FW-1:0] SMAX_F = FW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [FW-1:0] SMIN_F = -SMAX_F - 1;

    typedef struct packed {
        logic signed [DW-1:0] p;
        logic [N2W-1:0]       n2;
        logic                 neg;
        logic                 err;
        logic signed [DW-1:0] mn;
        logic [VW-1:0]        vn;
        logic                 last;
    } side_a_t;

    typedef struct packed {
        logic signed [DW-1:0] p;
        logic [DW-1:0]        q1;
        logic                 neg;
        logic                 err;
        logic signed [DW-1:0] mn;
        logic [VW-1:0]        vn;
        logic                 last;
    } side_b_t;

    typedef struct packed {
        logic signed [DW-1:0] p;
        logic                 neg;
        logic                 err;
        logic signed [DW-1:0] mn;
        logic [VW-1:0]        vn;
        logic                 last;
    } side_d_t;

    localparam int SAW = $bits(side_a_t);
    localparam int SBW = $bits(side_b_t);
    localparam int SDW = $bits(side_d_t);

    logic en;

    logic            b0_vld_reg;
    logic [N1W-1:0]  b0_n1_reg;
    side_a_t         b0_side_reg, b0_side_next;
    logic [DW-1:0]   absm;
    logic [N1W-1:0]  n1_next;

    logic            d1_vld;
    logic [DW-1:0]   d1_q;
    logic [SAW-1:0]  d1_raw;
    side_a_t         d1_side;
    side_b_t         d2_in_side;

    logic            d2_vld;
    logic [VW-1:0]   d2_q;
    logic [SBW-1:0]  d2_raw;

    logic            sq_vld;
    logic [RW-1:0]   sq_root;
    logic [SBW-1:0]  sq_raw;
    side_b_t         sq_side;

    logic            m1_vld_reg;
    logic [DW-1:0]   m1_mh_reg;
    logic [DDW-1:0]  m1_d_reg;
    side_b_t         m1_side_reg;
    logic [DW-1:0]   cap;

    logic            m2_vld_reg;
    logic [NQW-1:0]  m2_prod_reg;
    logic [DDW-1:0]  m2_d_reg;
    side_b_t         m2_side_reg;

    logic            m3_vld_reg;
    logic [NQW-1:0]  m3_nq_reg;
    logic [DDW-1:0]  m3_d_reg;
    side_d_t         m3_side_reg, m3_side_next;

    logic            d3_vld;
    logic [QCW-1:0]  d3_q;
    logic [SDW-1:0]  d3_raw;
    side_d_t         d3_side;

    logic            f1_vld_reg;
    logic [QCW-1:0]  f1_qc_reg;
    side_d_t         f1_side_reg;

    logic              out_vld_reg;
    apu_pkg::apu_out_t out_reg, out_next;
    logic signed [FW-1:0] px, qx, np_sum;

    assign en       = !out_vld_reg || !result_stall;
    assign in_ready = en;

    always_comb
    begin
        absm = in_word.mn[DW-1] ? (~in_word.mn + 1'b1) : in_word.mn;
        n1_next = {absm, {FB{1'b0}}} + N1W'(coef.c1 >> 1);
        b0_side_next.p    = in_word.p;
        b0_side_next.n2   = {in_word.vn, {FB{1'b0}}} + N2W'(coef.c2 >> 1);
        b0_side_next.neg  = in_word.mn[DW-1];
        b0_side_next.err  = in_word.err;
        b0_side_next.mn   = in_word.mn;
        b0_side_next.vn   = in_word.vn;
        b0_side_next.last = in_word.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_n1_reg   <= n1_next;
            b0_side_reg <= b0_side_next;
        end
    end

    // corrected mean magnitude
    apu_div #(.NW(N1W), .DNW(CW), .QW(DW), .SW(SAW)) u_div_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (b0_vld_reg),
        .num      (b0_n1_reg),
        .den      (coef.c1),
        .side_in  (b0_side_reg),
        .out_vld  (d1_vld),
        .quo      (d1_q),
        .side_out (d1_raw)
    );

    always_comb
    begin
        d1_side         = d1_raw;
        d2_in_side.p    = d1_side.p;
        d2_in_side.q1   = d1_q;
        d2_in_side.neg  = d1_side.neg;
        d2_in_side.err  = d1_side.err;
        d2_in_side.mn   = d1_side.mn;
        d2_in_side.vn   = d1_side.vn;
        d2_in_side.last = d1_side.last;
    end

    // corrected second moment, saturates to all ones
    apu_div #(.NW(N2W), .DNW(CW), .QW(VW), .SW(SBW)) u_div_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d1_vld),
        .num      (d1_side.n2),
        .den      (coef.c2),
        .side_in  (d2_in_side),
        .out_vld  (d2_vld),
        .quo      (d2_q),
        .side_out (d2_raw)
    );

    apu_sqrt #(.XW(XW), .SW(SBW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d2_vld),
        .x        ({d2_q, {FB{1'b0}}}),
        .side_in  (d2_raw),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .side_out (sq_raw)
    );

    always_comb
    begin
        sq_side = sq_raw;
        cap     = {1'b0, {VW{1'b1}}} + DW'(sq_side.neg);
        m3_side_next.p    = m2_side_reg.p;
        m3_side_next.neg  = m2_side_reg.neg;
        m3_side_next.err  = m2_side_reg.err || (m2_d_reg == '0);
        m3_side_next.mn   = m2_side_reg.mn;
        m3_side_next.vn   = m2_side_reg.vn;
        m3_side_next.last = m2_side_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= sq_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_mh_reg   <= (sq_side.q1 > cap) ? cap : sq_side.q1;
            m1_d_reg    <= DDW'(sq_root) + DDW'(coef.eps);
            m1_side_reg <= sq_side;

            m2_prod_reg <= NQW'(coef.lr) * NQW'(m1_mh_reg);
            m2_d_reg    <= m1_d_reg;
            m2_side_reg <= m1_side_reg;

            m3_nq_reg   <= m2_prod_reg + NQW'(m2_d_reg >> 1);
            m3_d_reg    <= m2_d_reg;
            m3_side_reg <= m3_side_next;
        end
    end

    // parameter step magnitude
    apu_div #(.NW(NQW), .DNW(DDW), .QW(QCW), .SW(SDW)) u_div_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (m3_vld_reg),
        .num      (m3_nq_reg),
        .den      (m3_d_reg),
        .side_in  (m3_side_reg),
        .out_vld  (d3_vld),
        .quo      (d3_q),
        .side_out (d3_raw)
    );

    always_comb
    begin
        d3_side = d3_raw;
        px      = FW'(f1_side_reg.p);
        qx      = $signed(FW'(f1_qc_reg));
        np_sum  = f1_side_reg.neg ? (px + qx) : (px - qx);
        if (f1_side_reg.err)
        begin
            out_next.new_param = f1_side_reg.p;
        end
        else if (np_sum > SMAX_F)
        begin
            out_next.new_param = DW'(SMAX_F);
        end
        else if (np_sum < SMIN_F)
        begin
            out_next.new_param = DW'(SMIN_F);
        end
        else
        begin
            out_next.new_param = DW'(np_sum);
        end
        out_next.new_mean   = f1_side_reg.mn;
        out_next.new_square = f1_side_reg.vn;
        out_next.div_error  = f1_side_reg.err;
        out_next.last_out   = f1_side_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg  <= d3_vld;
            out_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_qc_reg   <= (d3_q > QCLAMP) ? QCLAMP : d3_q;
            f1_side_reg <= d3_side;
            out_reg     <= out_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

/* design/adam_param_update_unit.sv */
// Top level of the Adam parameter update unit: registers, front, queue, back.
// Throughput: one element per cycle; the front, queue and back stall independently.
// Path: front pipeline, queue, input register, mean divider, square divider, root
// pipeline, multiply stages, step divider and output registers.
// The latency is set by the three one-bit-per-stage dividers and the root pipeline.
// Reset clears all valid bits and the queue and loads the register defaults.
`include "adam_param_update_unit_defines.svh"

module adam_param_update_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  apu_pkg::apu_in_t              item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output apu_pkg::apu_out_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [apu_pkg::IW-1:0]        cfg_index,
    input  logic [apu_pkg::CW-1:0]        cfg_data
);

    localparam int CW = apu_pkg::CW;
    localparam int MW = $bits(apu_pkg::apu_mid_t);

    logic [CW-1:0] step_size_reg, mean_decay_reg, square_decay_reg;
    logic [CW-1:0] mean_decay_power_reg, square_decay_power_reg, epsilon_reg;

    apu_pkg::apu_coef_t coef;
    apu_pkg::apu_fst_t  f_st;
    apu_pkg::apu_qst_t  q_st;
    apu_pkg::apu_mid_t  f_word, q_word;
    logic [MW-1:0]      q_raw;
    logic               f_vld, q_push_ready, q_vld, q_pop;

    function automatic logic [CW-1:0] clip(input logic [CW-1:0] c);
        clip = (c > apu_pkg::ONE) ? apu_pkg::ONE : c;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg          <= apu_pkg::STEP_SIZE_RST;
            mean_decay_reg         <= apu_pkg::MEAN_DECAY_RST;
            square_decay_reg       <= apu_pkg::SQUARE_DECAY_RST;
            mean_decay_power_reg   <= apu_pkg::MEAN_DECAY_POWER_RST;
            square_decay_power_reg <= apu_pkg::SQUARE_DECAY_POWER_RST;
            epsilon_reg            <= apu_pkg::EPSILON_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (apu_pkg::apu_reg_t'(cfg_index))
                apu_pkg::REG_STEP_SIZE:          step_size_reg          <= cfg_data;
                apu_pkg::REG_MEAN_DECAY:         mean_decay_reg         <= cfg_data;
                apu_pkg::REG_SQUARE_DECAY:       square_decay_reg       <= cfg_data;
                apu_pkg::REG_MEAN_DECAY_POWER:   mean_decay_power_reg   <= cfg_data;
                apu_pkg::REG_SQUARE_DECAY_POWER: square_decay_power_reg <= cfg_data;
                apu_pkg::REG_EPSILON:            epsilon_reg            <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        coef.lr  = clip(step_size_reg);
        coef.b1  = clip(mean_decay_reg);
        coef.nb1 = apu_pkg::ONE - coef.b1;
        coef.b2  = clip(square_decay_reg);
        coef.nb2 = apu_pkg::ONE - coef.b2;
        coef.c1  = apu_pkg::ONE - clip(mean_decay_power_reg);
        coef.c2  = apu_pkg::ONE - clip(square_decay_power_reg);
        coef.eps = clip(epsilon_reg);
    end

    apu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (item_valid),
        .item      (item),
        .coef      (coef),
        .out_ready (q_push_ready),
        .out_vld   (f_vld),
        .out_word  (f_word),
        .st        (f_st)
    );

    assign item_stall = f_st.stall;

    apu_fifo #(.DEPTH(QUEUE_DEPTH), .WW(MW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_vld   (f_vld),
        .push_ready (q_push_ready),
        .push_word  (f_word),
        .pop_vld    (q_vld),
        .pop_ready  (q_pop),
        .pop_word   (q_raw),
        .st         (q_st)
    );

    assign q_word = q_raw;

    apu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef         (coef),
        .in_vld       (q_vld),
        .in_ready     (q_pop),
        .in_word      (q_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `APU_NEVER(a_queue_full_and_empty, q_st.full && q_st.empty)
    `APU_IMPLY(a_stall_only_on_full_queue, item_stall, f_st.tail_vld && q_st.full)

endmodule
